/* hdl/sacl_pkg.sv */
// Package with shared types and constants of the set-associative cache tag store.
`default_nettype none
package sacl_pkg;
	localparam logic [2:0] REG_OFFSET  = 3'd0;
	localparam logic [2:0] REG_INDEX   = 3'd1;
	localparam logic [2:0] REG_MODE    = 3'd2;
	localparam logic [2:0] REG_HIT     = 3'd3;
	localparam logic [2:0] REG_PENALTY = 3'd4;

	localparam logic [1:0] MODE_LRU = 2'd0;
	localparam logic [1:0] MODE_LFU = 2'd1;

	typedef struct packed {
		logic [4:0]  offset_bits;
		logic [2:0]  index_bits;
		logic [1:0]  replace_mode;
		logic [15:0] hit_cycles;
		logic [15:0] miss_penalty;
	} cfg_t;
endpackage
`default_nettype wire

/* hdl/sacl_front.sv */
// Front end: takes addresses, splits them into set and tag, and queues the lookups.
`default_nettype none
module sacl_front
	import sacl_pkg::*;
#(
	parameter int SET_W = 6,
	parameter int MAX_IB = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [31:0]      in_address,
	output logic                  q_valid,
	input  wire logic             q_pop,
	output logic [SET_W-1:0]      q_set,
	output logic [31:0]           q_tag
);
	logic [SET_W-1:0] set_q [2];
	logic [31:0]      tag_q [2];
	logic [1:0]       wp_q, rp_q;
	logic [2:0]       ib;
	logic [5:0]       shift;
	logic [31:0]      shifted, mask;
	logic             push;

	always_comb begin
		ib = (32'(cfg.index_bits) > MAX_IB) ? 3'(MAX_IB) : cfg.index_bits;
		shifted = in_address >> cfg.offset_bits;
		mask = ~(32'hFFFF_FFFF << ib);
		shift = 6'(cfg.offset_bits) + 6'(ib);
	end

	assign in_stall = (wp_q[1] != rp_q[1]) && (wp_q[0] == rp_q[0]);
	assign push = in_valid && !in_stall;
	assign q_valid = wp_q != rp_q;
	assign q_set = set_q[rp_q[0]];
	assign q_tag = tag_q[rp_q[0]];

	always_ff @(posedge clk) begin
		if (push) begin
			set_q[wp_q[0]] <= SET_W'(shifted & mask);
			tag_q[wp_q[0]] <= shift[5] ? 32'd0 : (in_address >> shift[4:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (q_pop && q_valid) rp_q <= rp_q + 2'd1;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q - rp_q) <= 2'd2) else $error("lookup queue overfilled");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |=> $stable(rp_q)) else $error("pop from empty queue");
	a_push_moves: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> wp_q == $past(wp_q) + 2'd1) else $error("push lost");
endmodule
`default_nettype wire

/* hdl/sacl_back.sv */
// Back end: reads a set, compares ways, picks a victim and writes the set back.
`default_nettype none
module sacl_back
	import sacl_pkg::*;
#(
	parameter int SETS = 64,
	parameter int WAYS = 4,
	parameter int COUNT_WIDTH = 32,
	parameter int SET_W = 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             q_valid,
	output logic                  q_pop,
	input  wire logic [SET_W-1:0] q_set,
	input  wire logic [31:0]      q_tag,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  hit,
	output logic [1:0]            way,
	output logic [31:0]           access_total,
	output logic [31:0]           miss_total,
	output logic [31:0]           cycle_total
);
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CW = COUNT_WIDTH;
	localparam logic [CW-1:0] CMAX = '1;
	localparam int ROWS = SETS;
	// The cycle sums need room for a 16-bit weight even when the counters are narrower.
	localparam int SW = (CW > 16) ? CW + 1 : 17;

	typedef struct packed {
		logic [31:0]   tag;
		logic [CW-1:0] uses;
		logic [CW-1:0] stamp;
	} line_t;

	// One row per set holds all its ways; the valid bits live in flip-flops.
	line_t          mem [ROWS][WAYS];
	logic [WAYS-1:0] vld_q [ROWS];
	line_t          rd_s1 [WAYS];
	logic [WAYS-1:0] rv_s1;
	logic [SET_W-1:0] set_s1;
	logic [31:0]     tag_s1;
	logic            busy_s1;

	logic [CW-1:0] acc_q, miss_q, cyc_q;
	logic          ov_q;

	logic [WAYS-1:0] match;
	logic            h;
	logic [WAY_W-1:0] hw, fw, vw, sel;
	logic            free_any;
	logic [CW-1:0]   acc_n, miss_n, cyc_a, cyc_n;
	logic [SW-1:0]   t1, t2;
	logic [CW:0]     t3;

	assign q_pop = q_valid && !busy_s1 && !(ov_q && out_stall);

	always_comb begin
		h = 1'b0; hw = '0; free_any = 1'b0; fw = '0; vw = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = rv_s1[w] && rd_s1[w].tag == tag_s1;
			if (match[w]) begin h = 1'b1; hw = WAY_W'(w); end
			if (!rv_s1[w]) begin free_any = 1'b1; fw = WAY_W'(w); end
		end
		for (int w = 1; w < WAYS; w++) begin
			if (cfg.replace_mode == MODE_LRU) begin
				if (rd_s1[w].stamp < rd_s1[vw].stamp) vw = WAY_W'(w);
			end else if (cfg.replace_mode == MODE_LFU) begin
				if (rd_s1[w].uses < rd_s1[vw].uses) vw = WAY_W'(w);
			end
		end
		sel = h ? hw : (free_any ? fw : vw);
		acc_n = (acc_q == CMAX) ? CMAX : acc_q + 1'b1;
		miss_n = (h || miss_q == CMAX) ? miss_q : miss_q + 1'b1;
		t1 = SW'(cyc_q) + (h ? SW'(0) : SW'(cfg.miss_penalty));
		cyc_a = (t1 > SW'(CMAX)) ? CMAX : CW'(t1);
		t2 = SW'(cyc_a) + SW'(cfg.hit_cycles);
		cyc_n = (t2 > SW'(CMAX)) ? CMAX : CW'(t2);
		t3 = {1'b0, rd_s1[sel].uses} + 1'b1;
	end

	function automatic logic [31:0] clamp(input logic [CW-1:0] v);
		logic [CW:0] x;
		x = {1'b0, v};
		return (x > (CW+1)'(33'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(x);
	endfunction

	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int w = 0; w < WAYS; w++) rd_s1[w] <= mem[q_set][w];
			set_s1 <= q_set;
			tag_s1 <= q_tag;
		end
		if (busy_s1) begin
			mem[set_s1][sel].tag <= tag_s1;
			mem[set_s1][sel].stamp <= acc_n;
			mem[set_s1][sel].uses <= !h ? CW'(1) :
				(t3[CW] ? CMAX : t3[CW-1:0]);
			hit <= h;
			way <= 2'(sel);
			access_total <= clamp(acc_n);
			miss_total <= clamp(miss_n);
			cycle_total <= clamp(cyc_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) vld_q[r] <= '0;
			rv_s1 <= '0;
			busy_s1 <= 1'b0;
			ov_q <= 1'b0;
			out_valid <= 1'b0;
			acc_q <= '0;
			miss_q <= '0;
			cyc_q <= '0;
		end else begin
			if (q_pop) rv_s1 <= vld_q[q_set];
			busy_s1 <= q_pop;
			if (busy_s1) begin
				vld_q[set_s1][sel] <= 1'b1;
				acc_q <= acc_n;
				miss_q <= miss_n;
				cyc_q <= cyc_n;
				out_valid <= 1'b1;
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
				ov_q <= 1'b0;
			end
		end
	end

	a_onehot_hit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> $onehot0(match)) else $error("tag found in two ways");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !(out_valid && out_stall)) else $error("result overwritten");
	a_acc_mono: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |=> acc_q >= $past(acc_q)) else $error("access count fell");
endmodule
`default_nettype wire

/* hdl/set_assoc_cache_lru_lfu_core.sv */
// Top level of the set-associative cache tag store with LRU/LFU replacement.
//  channel | direction | handshake          | beat
//  in      | input     | in_valid/in_stall  | address
//  out     | output    | out_valid/out_stall| hit, way, access/miss/cycle totals
//  cfg     | APB       | psel/penable       | one register write or read
// A lookup in the back end is a set read, then compare, victim and write-back.
// The back end takes no new address until its lookup is written back; a two-entry queue separates the ends.
// The result is registered; an accepted address passes the queue and the set read before it.
// Reset clears valid bits, counters and registers at once; no clearing pass.
// A stalled result holds the back end, which then backs up the queue and in_stall.
`default_nettype none
module set_assoc_cache_lru_lfu_core
	import sacl_pkg::*;
#(
	parameter int SETS = 64,
	parameter int WAYS = 4,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] address,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             hit,
	output logic [1:0]       way,
	output logic [31:0]      access_total,
	output logic [31:0]      miss_total,
	output logic [31:0]      cycle_total
);
	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int MAX_IB = $clog2(SETS + 1) - 1;

	cfg_t cfg_q;
	logic q_valid, q_pop;
	logic [SET_W-1:0] q_set;
	logic [31:0] q_tag;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{offset_bits: 5'd0, index_bits: 3'd6, replace_mode: 2'd0,
				hit_cycles: 16'd1, miss_penalty: 16'd100};
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_OFFSET:  cfg_q.offset_bits <= pwdata[4:0];
				REG_INDEX:   cfg_q.index_bits <= pwdata[2:0];
				REG_MODE:    cfg_q.replace_mode <= pwdata[1:0];
				REG_HIT:     cfg_q.hit_cycles <= pwdata[15:0];
				REG_PENALTY: cfg_q.miss_penalty <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_OFFSET:  prdata = {27'd0, cfg_q.offset_bits};
			REG_INDEX:   prdata = {29'd0, cfg_q.index_bits};
			REG_MODE:    prdata = {30'd0, cfg_q.replace_mode};
			REG_HIT:     prdata = {16'd0, cfg_q.hit_cycles};
			REG_PENALTY: prdata = {16'd0, cfg_q.miss_penalty};
			default:     prdata = 32'd0;
		endcase
	end

	sacl_front #(.SET_W(SET_W), .MAX_IB(MAX_IB)) u_front (
		.clk, .arst_n, .cfg(cfg_q), .in_valid, .in_stall, .in_address(address),
		.q_valid, .q_pop, .q_set, .q_tag
	);

	sacl_back #(.SETS(SETS), .WAYS(WAYS), .COUNT_WIDTH(COUNT_WIDTH), .SET_W(SET_W)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid, .q_pop, .q_set, .q_tag,
		.out_valid, .out_stall, .hit, .way, .access_total, .miss_total, .cycle_total
	);
endmodule
`default_nettype wire
